@@ sv/tbaq_pkg.sv @@
// ----------------------------------------------------------------------------
// tbaq_pkg
// Shared types and constants for the timed button action queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tbaq_pkg;

  // command codes
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_MACRO = 2'd2;

  // action kinds
  localparam logic [1:0] KIND_PRESS = 2'd0;
  localparam logic [1:0] KIND_PAD   = 2'd1;
  localparam logic [1:0] KIND_WAIT  = 2'd2;

  localparam logic [3:0]  HAT_CENTER      = 4'd8;
  localparam logic [13:0] SOFT_RESET_MASK = 14'h000F;  // X|Y|A|B
  localparam logic [31:0] SOFT_RESET_MS   = 32'd150;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] duration;
    logic [13:0] mask;
  } entry_t;

  // commit strobes from the runner to the ring
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wdata;
  } ring_ctrl_t;

endpackage

`default_nettype wire

@@ sv/tbaq_req_if.sv @@
// ----------------------------------------------------------------------------
// tbaq_req_if
// Request channel: valid/ready plus one command and its action fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbaq_req_if import tbaq_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  action_kind;
  logic [31:0] duration_ms;
  logic [13:0] hold_mask;
  logic [1:0]  direction;

  modport source (output valid, cmd, action_kind, duration_ms, hold_mask, direction,
                  input ready);
  modport sink   (input valid, cmd, action_kind, duration_ms, hold_mask, direction,
                  output ready);
endinterface

`default_nettype wire

@@ sv/tbaq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tbaq_rsp_if
// Result channel: valid/ready plus status and report fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbaq_rsp_if import tbaq_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [13:0] buttons;
  logic [3:0]  hat;
  logic [7:0]  pending;

  modport source (output valid, accepted, buttons, hat, pending, input ready);
  modport sink   (input valid, accepted, buttons, hat, pending, output ready);
endinterface

`default_nettype wire

@@ sv/tbaq_ring.sv @@
// ----------------------------------------------------------------------------
// tbaq_ring
// Ring queue of actions: one synchronous memory, read and write pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module tbaq_ring import tbaq_pkg::*; #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rd_en,   // fetch head entry, data next cycle
  input  wire ring_ctrl_t ctrl,
  output entry_t          rdata,
  output logic            empty,
  output logic            full,
  output logic [AW:0]     count
);

  entry_t        mem [DEPTH];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= ctrl.wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (ctrl.pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
    end
  end

  assign empty = (rd_ptr == wr_ptr);
  assign full  = (wrap_inc(wr_ptr) == rd_ptr);

  always_comb begin
    if (wr_ptr >= rd_ptr) begin
      count = {1'b0, wr_ptr} - {1'b0, rd_ptr};
    end else begin
      count = (AW + 1)'(DEPTH) - {1'b0, rd_ptr} + {1'b0, wr_ptr};
    end
  end

endmodule

`default_nettype wire

@@ sv/timed_button_action_queue_top.sv @@
// ----------------------------------------------------------------------------
// timed_button_action_queue_top
// Timed controller action queue with a millisecond-tick runner.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted in ST_IDLE, where the queue memory's registered read is
//   issued, then committed in ST_EXEC (read-modify-write) once the result register is free
//   or draining; the result is registered at commit, and no new request is taken until then.
// A result held by a stalled sink does not block the next accept.
// Reset (rst, synchronous): empty queue, runner idle, no buttons, hat neutral.
// The queue memory is not cleared; only entries already pushed are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_button_action_queue_top import tbaq_pkg::*; #(
  parameter int QUEUE_DEPTH = 128
) (
  input wire logic  clk,
  input wire logic  rst,
  tbaq_req_if.sink  req,
  tbaq_rsp_if.source rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  // two-step sequencer: accept (memory read issued), then commit
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;

  // held request
  logic [1:0]  cmd;
  logic [1:0]  kind;
  logic [31:0] dur;
  logic [13:0] mask;
  logic [1:0]  dir;

  // runner state
  logic        running;
  logic        applied;
  logic [31:0] time_left;
  logic [1:0]  cur_kind;
  logic [13:0] cur_mask;
  logic [13:0] buttons;
  logic [3:0]  hat;

  logic        running_next;
  logic        applied_next;
  logic [31:0] time_left_next;
  logic [1:0]  cur_kind_next;
  logic [13:0] cur_mask_next;
  logic [13:0] buttons_next;
  logic [3:0]  hat_next;
  logic        ok;

  // ring interface
  ring_ctrl_t    ring_cmd;
  ring_ctrl_t    ring_ctrl;
  entry_t        head;
  logic          q_empty;
  logic          q_full;
  logic [AW:0]   q_count;
  logic [AW:0]   q_count_next;
  logic [31:0]   pend_wide;

  logic req_take;
  logic commit;

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  // commit once the output register is free or being drained
  assign commit    = (state == ST_EXEC) && (!rsp.valid || rsp.ready);

  tbaq_ring #(.DEPTH(QUEUE_DEPTH)) u_ring (
    .clk   (clk),
    .rst   (rst),
    .rd_en (req_take),
    .ctrl  (ring_ctrl),
    .rdata (head),
    .empty (q_empty),
    .full  (q_full),
    .count (q_count)
  );

  // ring strobes only fire in the commit cycle
  always_comb begin
    ring_ctrl      = ring_cmd;
    ring_ctrl.push = ring_cmd.push && commit;
    ring_ctrl.pop  = ring_cmd.pop && commit;
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cmd  <= req.cmd;
      kind <= req.action_kind;
      dur  <= req.duration_ms;
      mask <= req.hold_mask;
      dir  <= req.direction;
    end
  end

  // Step logic: one command against the current runner state.
  always_comb begin
    running_next   = running;
    applied_next   = applied;
    time_left_next = time_left;
    cur_kind_next  = cur_kind;
    cur_mask_next  = cur_mask;
    buttons_next   = buttons;
    hat_next       = hat;
    ok             = 1'b0;
    ring_cmd       = '0;

    case (cmd)
      CMD_PUSH: begin
        ok                      = !q_full;
        ring_cmd.push           = !q_full;
        ring_cmd.wdata.kind     = kind;
        ring_cmd.wdata.duration = dur;
        // pad keeps its direction in the mask slot; wait/unknown store zero
        if (kind == KIND_PRESS) begin
          ring_cmd.wdata.mask = mask;
        end else if (kind == KIND_PAD) begin
          ring_cmd.wdata.mask = {12'd0, dir};
        end else begin
          ring_cmd.wdata.mask = '0;
        end
      end
      CMD_MACRO: begin
        ok                      = !q_full;
        ring_cmd.push           = !q_full;
        ring_cmd.wdata.kind     = KIND_PRESS;
        ring_cmd.wdata.duration = SOFT_RESET_MS;
        ring_cmd.wdata.mask     = SOFT_RESET_MASK;
      end
      CMD_TICK: begin
        ok = 1'b1;
        if (!running) begin
          // idle runner picks up the head entry, if any
          if (!q_empty) begin
            ring_cmd.pop   = 1'b1;
            cur_kind_next  = head.kind;
            time_left_next = head.duration;
            cur_mask_next  = head.mask;
            running_next   = 1'b1;
            applied_next   = 1'b0;
          end
        end else if (time_left != '0) begin
          time_left_next = time_left - 32'd1;
        end
        if (running_next) begin
          // the starting tick applies the action
          if (!applied_next) begin
            applied_next = 1'b1;
            if (cur_kind_next == KIND_PRESS) begin
              buttons_next = buttons_next | cur_mask_next;
            end else if (cur_kind_next == KIND_PAD) begin
              hat_next = {1'b0, cur_mask_next[1:0], 1'b0};
            end
          end
          // time out: undo (zero duration releases in the same tick)
          if (time_left_next == '0) begin
            if (cur_kind_next == KIND_PRESS) begin
              buttons_next = buttons_next & ~cur_mask_next;
            end else if (cur_kind_next == KIND_PAD) begin
              hat_next = HAT_CENTER;
            end
            running_next = 1'b0;
          end
        end
      end
      default: begin
        ok = 1'b0;  // unknown command: no change
      end
    endcase
  end

  // queued count after this step, plus the running action
  always_comb begin
    q_count_next = q_count;
    if (ring_cmd.push) begin
      q_count_next = q_count + 1'b1;
    end else if (ring_cmd.pop) begin
      q_count_next = q_count - 1'b1;
    end
    pend_wide = 32'(q_count_next) + 32'(running_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      running   <= 1'b0;
      applied   <= 1'b0;
      time_left <= '0;
      cur_kind  <= '0;
      cur_mask  <= '0;
      buttons   <= '0;
      hat       <= HAT_CENTER;
      rsp.valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_take) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (commit) begin
        running   <= running_next;
        applied   <= applied_next;
        time_left <= time_left_next;
        cur_kind  <= cur_kind_next;
        cur_mask  <= cur_mask_next;
        buttons   <= buttons_next;
        hat       <= hat_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.accepted <= ok;
      rsp.buttons  <= buttons_next;
      rsp.hat      <= hat_next;
      rsp.pending  <= pend_wide[7:0];
    end
  end

endmodule

`default_nettype wire

@@ tb/timed_button_action_queue_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_button_action_queue_top_test
// Self-checking bench for the timed button action queue. A driver feeds
// requests (pushes, millisecond ticks, soft-reset macros, unknown commands)
// in random bursts. An in-bench predictor of the ring and the runner computes
// each report, and a monitor compares the reports in order, field by field.
// ----------------------------------------------------------------------------

module timed_button_action_queue_top_test;
  import tbaq_pkg::*;

  localparam int QUEUE_DEPTH = 128;
  localparam int ITEM_TARGET = 960;     // random part stops once this many requests are queued
  localparam int CYCLE_LIMIT = 200000;  // several times the slowest legal run
  localparam int MAX_SHOWN   = 10;
  localparam int DRAIN_WAIT  = 12;      // quiet tail after the last report; leave some margin

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_NONE = 2'd3;  // unknown command, ignored by the block
  localparam logic [1:0] KIND_ODD = 2'd3;  // unknown kind, runs like a wait

  // one request as the bench queues it; hold = wait for all reports before sending
  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  kind;
    logic [31:0] dur;
    logic [13:0] mask;
    logic [1:0]  dir;
    bit          hold;
  } action_req_t;

  typedef struct packed {
    logic        accepted;
    logic [13:0] buttons;
    logic [3:0]  hat;
    logic [7:0]  pending;
  } report_t;

  logic clk;
  logic rst;

  tbaq_req_if req_ch ();
  tbaq_rsp_if rsp_ch ();

  timed_button_action_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Shadow of the block: the ring of actions and the runner.
  // Only slots that were pushed are ever read, so the ring needs no clearing.
  // --------------------------------------------------------------------------
  entry_t      ring_img [QUEUE_DEPTH];
  int          ring_rd      = 0;
  int          ring_wr      = 0;
  bit          run_busy     = 1'b0;
  bit          run_applied  = 1'b0;
  logic [31:0] run_left     = '0;
  logic [1:0]  run_kind     = KIND_PRESS;
  logic [13:0] run_mask     = '0;
  logic [13:0] held_buttons = '0;
  logic [3:0]  held_hat     = HAT_CENTER;

  action_req_t stim_q [$];    // requests waiting to be sent
  report_t     report_q [$];  // reports predicted but not yet seen

  int mismatches      = 0;
  int reports_checked = 0;
  int requests_sent   = 0;
  int pushes_refused  = 0;
  int ticks_sent      = 0;
  int peak_pending    = 0;
  int cycle_count     = 0;

  // Advance the shadow by one request and return the report it must produce.
  function automatic report_t predict_report(input action_req_t r);
    report_t rep;
    entry_t  slot;
    int      nxt;
    int      queued;
    rep.accepted = 1'b0;
    slot.kind     = r.kind;
    slot.duration = r.dur;
    slot.mask     = '0;
    if (r.cmd == CMD_PUSH || r.cmd == CMD_MACRO) begin
      if (r.cmd == CMD_MACRO) begin
        slot.kind     = KIND_PRESS;
        slot.duration = SOFT_RESET_MS;
        slot.mask     = SOFT_RESET_MASK;
      end else if (r.kind == KIND_PRESS) begin
        slot.mask = r.mask;
      end else if (r.kind == KIND_PAD) begin
        slot.mask = {12'd0, r.dir};
      end
      // one slot always stays free
      nxt = (ring_wr + 1) % QUEUE_DEPTH;
      if (nxt != ring_rd) begin
        ring_img[ring_wr] = slot;
        ring_wr = nxt;
        rep.accepted = 1'b1;
      end
    end else if (r.cmd == CMD_TICK) begin
      rep.accepted = 1'b1;
      if (!run_busy) begin
        if (ring_rd != ring_wr) begin
          run_kind    = ring_img[ring_rd].kind;
          run_left    = ring_img[ring_rd].duration;
          run_mask    = ring_img[ring_rd].mask;
          ring_rd     = (ring_rd + 1) % QUEUE_DEPTH;
          run_busy    = 1'b1;
          run_applied = 1'b0;
        end
      end else if (run_left != 0) begin
        run_left = run_left - 1;
      end
      if (run_busy) begin
        // the starting tick applies; a zero time left releases in the same tick
        if (!run_applied) begin
          run_applied = 1'b1;
          if (run_kind == KIND_PRESS) held_buttons = held_buttons | run_mask;
          else if (run_kind == KIND_PAD) held_hat = {1'b0, run_mask[1:0], 1'b0};
        end
        if (run_left == 0) begin
          // release clears the bits even if some other action had set them
          if (run_kind == KIND_PRESS) held_buttons = held_buttons & ~run_mask;
          else if (run_kind == KIND_PAD) held_hat = HAT_CENTER;
          run_busy = 1'b0;
        end
      end
    end
    // unknown command: nothing changes, accepted stays low
    queued = (ring_wr >= ring_rd) ? ring_wr - ring_rd : QUEUE_DEPTH - ring_rd + ring_wr;
    rep.buttons = held_buttons;
    rep.hat     = held_hat;
    rep.pending = 8'(queued + (run_busy ? 1 : 0));
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_req(input logic [1:0] c, input logic [1:0] kd,
                                  input logic [31:0] d, input logic [13:0] m,
                                  input logic [1:0] dr);
    action_req_t a;
    a.cmd  = c;
    a.kind = kd;
    a.dur  = d;
    a.mask = m;
    a.dir  = dr;
    a.hold = 1'b0;
    stim_q.push_back(a);
  endfunction

  function automatic action_req_t random_push(input int max_dur);
    action_req_t a;
    int          roll;
    roll   = $urandom_range(0, 19);
    a.cmd  = CMD_PUSH;
    if (roll < 9) a.kind = KIND_PRESS;
    else if (roll < 15) a.kind = KIND_PAD;
    else if (roll < 18) a.kind = KIND_WAIT;
    else a.kind = KIND_ODD;
    a.dur  = $urandom_range(0, max_dur);
    a.mask = 14'($urandom);
    a.dir  = 2'($urandom);
    a.hold = 1'b0;
    return a;
  endfunction

  // ticks carry random junk in the unused fields; the block must ignore it
  function automatic action_req_t random_tick();
    action_req_t a;
    a.cmd  = CMD_TICK;
    a.kind = 2'($urandom);
    a.dur  = $urandom;
    a.mask = 14'($urandom);
    a.dir  = 2'($urandom);
    a.hold = 1'b0;
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: sends the head of stim_q in bursts with random gaps.
  // The shadow advances at the accepting edge, so reports queue in order.
  // --------------------------------------------------------------------------
  int      burst_left = 0;
  int      gap_left   = 0;
  report_t next_rep;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        next_rep = predict_report(stim_q[0]);
        if (stim_q[0].cmd == CMD_TICK) ticks_sent++;
        if ((stim_q[0].cmd == CMD_PUSH || stim_q[0].cmd == CMD_MACRO) && !next_rep.accepted)
          pushes_refused++;
        if (int'(next_rep.pending) > peak_pending) peak_pending = next_rep.pending;
        report_q.push_back(next_rep);
        void'(stim_q.pop_front());
        requests_sent++;
      end
      if (gap_left != 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (stim_q.size() == 0 || (stim_q[0].hold && report_q.size() != 0)) begin
        // nothing left, or a hold-off until every report is back
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= stim_q[0].cmd;
        req_ch.action_kind <= stim_q[0].kind;
        req_ch.duration_ms <= stim_q[0].dur;
        req_ch.hold_mask   <= stim_q[0].mask;
        req_ch.direction   <= stim_q[0].dir;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a third of the bursts run straight into the next one
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each report against the oldest prediction, and stalls
  // on a rotating 8-bit ready pattern that is re-chosen now and then.
  // --------------------------------------------------------------------------
  report_t    want;
  logic [7:0] stall_pat  = 8'hFF;
  int         pat_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        reports_checked++;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("[%0t] unexpected report: acc=%0b buttons=%h hat=%0d pending=%0d",
                     $realtime, rsp_ch.accepted, rsp_ch.buttons, rsp_ch.hat, rsp_ch.pending);
        end else begin
          want = report_q.pop_front();
          if (rsp_ch.accepted !== want.accepted || rsp_ch.buttons !== want.buttons ||
              rsp_ch.hat !== want.hat || rsp_ch.pending !== want.pending) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("[%0t] report %0d: expected acc=%0b buttons=%h hat=%0d pending=%0d,",
                       $realtime, reports_checked, want.accepted, want.buttons, want.hat,
                       want.pending);
              $display("    got acc=%0b buttons=%h hat=%0d pending=%0d",
                       rsp_ch.accepted, rsp_ch.buttons, rsp_ch.hat, rsp_ch.pending);
            end
          end
        end
      end
      if (pat_left == 0) begin
        // all-ready stretches, or a random pattern with at least one ready in eight
        stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        pat_left  = $urandom_range(16, 160);
      end else begin
        pat_left--;
      end
      rsp_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still due", CYCLE_LIMIT, report_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    action_req_t a;
    int          k;
    int          n;
    int          pick;
    int          need;
    int          done_ticks;
    bit          fill_done;

    // known values on every input before the first edge
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = CMD_PUSH;
    req_ch.action_kind = KIND_PRESS;
    req_ch.duration_ms = '0;
    req_ch.hold_mask   = '0;
    req_ch.direction   = 2'd0;
    rsp_ch.ready       = 1'b0;

    // ---- directed part ----
    add_req(CMD_TICK, KIND_PRESS, 32'd0, 14'h0000, 2'd0);          // idle tick, empty queue
    add_req(CMD_NONE, KIND_ODD, 32'hFFFF_FFFF, 14'h3FFF, 2'd3);    // unknown command
    add_req(CMD_PUSH, KIND_PRESS, 32'd0, 14'h3FFF, 2'd3);          // all buttons, zero time
    add_req(CMD_TICK, KIND_PRESS, 32'd0, 14'h0000, 2'd0);          // apply and release at once
    add_req(CMD_PUSH, KIND_PRESS, 32'd2, 14'h0001, 2'd0);
    add_req(CMD_PUSH, KIND_PRESS, 32'd0, 14'h2001, 2'd0);          // shares bit 0 with the last
    for (k = 0; k < 4; k++)
      add_req(CMD_PUSH, KIND_PAD, (k == 0) ? 32'd1 : 32'd0, 14'h3FFF, 2'(k));  // each direction
    add_req(CMD_PUSH, KIND_WAIT, 32'd1, 14'h3FFF, 2'd3);           // wait ignores mask and dir
    add_req(CMD_PUSH, KIND_ODD, 32'd0, 14'h3FFF, 2'd3);            // unknown kind acts as wait
    for (k = 0; k < 12; k++)
      add_req(CMD_TICK, KIND_PRESS, 32'd0, 14'h0000, 2'd0);
    add_req(CMD_MACRO, KIND_PAD, 32'd7, 14'h0000, 2'd1);           // soft reset, 150 ms
    add_req(CMD_TICK, KIND_PRESS, 32'd0, 14'h0000, 2'd0);

    // ---- random part, in episodes ----
    fill_done = 1'b0;
    while (stim_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (!fill_done && stim_q.size() > 400) begin
        // fill the ring past capacity once every report is back, then tick it down
        for (k = 0; k < QUEUE_DEPTH + 3; k++) begin
          a = random_push(1);
          if (k == 0) a.hold = 1'b1;
          stim_q.push_back(a);
        end
        for (k = 0; k < 200; k++) stim_q.push_back(random_tick());
        fill_done = 1'b1;
      end else if (pick < 65) begin
        // well-formed: a few actions with enough ticks to play them all out
        n          = $urandom_range(1, 6);
        need       = 0;
        done_ticks = 0;
        for (k = 0; k < n; k++) begin
          a = random_push(($urandom_range(0, 3) == 0) ? 12 : 3);
          need += int'(a.dur) + 1;
          stim_q.push_back(a);
          repeat ($urandom_range(0, 2)) begin
            stim_q.push_back(random_tick());
            done_ticks++;
          end
        end
        n = ((need > done_ticks) ? need - done_ticks : 0) + $urandom_range(0, 3);
        repeat (n) stim_q.push_back(random_tick());
      end else if (pick < 88) begin
        // pushes and ticks mixed item by item
        repeat ($urandom_range(4, 16)) begin
          if ($urandom_range(0, 1) == 0) stim_q.push_back(random_push(2));
          else stim_q.push_back(random_tick());
        end
      end else if (pick < 97) begin
        // noise: any command, any fields, short durations
        repeat ($urandom_range(3, 10)) begin
          a = random_push(6);
          a.cmd = 2'($urandom);
          stim_q.push_back(a);
        end
      end else begin
        // soft-reset macro played out in full
        a = random_push(0);
        a.cmd = CMD_MACRO;
        stim_q.push_back(a);
        repeat (152) stim_q.push_back(random_tick());
      end
    end

    // long holds last, since a huge duration parks the runner for good
    a = random_push(0);
    a.kind = KIND_PRESS;
    a.dur  = $urandom;
    stim_q.push_back(a);
    add_req(CMD_PUSH, KIND_PAD, 32'hFFFF_FFFF, 14'h0000, 2'($urandom));
    for (k = 0; k < 4; k++) begin
      a = random_push(0);
      a.dur = (k == 0) ? 32'hFFFF_FFFF : $urandom;
      stim_q.push_back(a);
    end
    add_req(CMD_MACRO, KIND_PRESS, 32'd0, 14'h0000, 2'd0);
    repeat (10) stim_q.push_back(random_tick());

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // everything sent and every report back, then a quiet tail for stray reports
    while (stim_q.size() != 0 || report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (report_q.size() != 0) begin
      $display("%0d reports never arrived", report_q.size());
      mismatches += report_q.size();
    end

    $display("Sent %0d requests (%0d ticks), %0d pushes refused on a full ring, peak pending %0d.",
             requests_sent, ticks_sent, pushes_refused, peak_pending);
    $display("Checked %0d reports, %0d mismatches.", reports_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
